// ===== design/i2c_bit_level_master_top_defines.svh =====
// Assertion macros for the I2C bit-level master.
// Included by the top level; the macros refer to its clock and reset.
`ifndef I2C_BIT_LEVEL_MASTER_TOP_DEFINES_SVH
`define I2C_BIT_LEVEL_MASTER_TOP_DEFINES_SVH

// Condition and consequence in the same cycle.
`define IBM_ASSERT_SAME(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Consequence in the following cycle.
`define IBM_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== design/ibm_pkg.sv =====
// Shared types and constants of the I2C bit-level master.
// No dependencies; every module imports it.
package ibm_pkg;

   localparam int WAIT_WIDTH = 16;
   localparam int DELAY_W = 16;
   localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(5);

   // Queue depth between front and back; must be a power of two.
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);

   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_START = 3'd1;
   localparam logic [2:0] OP_STOP  = 3'd2;
   localparam logic [2:0] OP_WRITE = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;
   localparam logic [2:0] OP_NACK  = 3'd5;

   typedef enum logic [2:0] {
      CMD_TICK,
      CMD_START,
      CMD_STOP,
      CMD_WRITE,
      CMD_READ,
      CMD_NACK
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] tx_byte;
      logic       sda_in;
   } q_entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

endpackage

// ===== design/ibm_if.sv =====
// Valid/ready channel interfaces for the I2C bit-level master.
// No dependencies.
interface ibm_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] opcode;
   logic [7:0] tx_byte;
   logic       sda_in;

   modport source (output valid, opcode, tx_byte, sda_in, input ready);
   modport sink (input valid, opcode, tx_byte, sda_in, output ready);
endinterface

interface ibm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_out;
   logic       sda_out;
   logic       busy_res;
   logic       done_res;
   logic [7:0] rx_byte;
   logic       ack_ok;

   modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_byte, ack_ok,
                   input ready);
   modport sink (input valid, scl_out, sda_out, busy_res, done_res, rx_byte, ack_ok,
                 output ready);
endinterface

// ===== design/i2c_bit_level_master_top.sv =====
// Top level of the I2C bit-level master: front end, queue and sequencer.
// Depends on ibm_pkg, the channel interfaces, ibm_front, ibm_queue, ibm_back
// and the assertion macros header.
`include "i2c_bit_level_master_top_defines.svh"

// The block takes one request transaction per clock while the queue is not full, and
// returns exactly one response transaction for each, in order. Every tick or command
// is a single step of the pin sequencer in the back end, so the sustained rate is
// one transaction per cycle while responses are not stalled; each request passes
// through the queue and its response is registered in the back end. A two-entry
// queue between the front end and the sequencer absorbs response stalls. The delay
// register is written through csr_we and csr_wdata and takes effect at the next wait.
module i2c_bit_level_master_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [ibm_pkg::DELAY_W-1:0] csr_wdata,
   ibm_req_if.sink                     req,
   ibm_rsp_if.source                   rsp
);
   import ibm_pkg::*;

   q_status_type q_status;
   q_entry_type  push_entry, pop_entry;
   logic         push, pop;

   ibm_front u_front (
      .req        (req),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   ibm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .q_status   (q_status)
   );

   ibm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .pop_entry (pop_entry),
      .q_status  (q_status),
      .pop       (pop),
      .rsp       (rsp)
   );

   `IBM_ASSERT_SAME(a_pop_not_empty, pop, !q_status.empty, "pop from an empty queue")
   `IBM_ASSERT_SAME(a_done_idle, rsp.valid && rsp.done_res, !rsp.busy_res, "done while busy")
   `IBM_ASSERT_NEXT(a_push_fills, push && !pop, !q_status.empty, "queue lost a transaction")

endmodule

// ===== design/ibm_front.sv =====
// Front end: accepts request transactions and classifies the opcode.
// Depends on ibm_pkg and ibm_req_if.
module ibm_front (
   ibm_req_if.sink            req,
   input  ibm_pkg::q_status_type q_status,
   output logic               push,
   output ibm_pkg::q_entry_type push_entry
);
   import ibm_pkg::*;

   cmd_type cmd;

   always_comb begin
      case (req.opcode)
         OP_START: cmd = CMD_START;
         OP_STOP:  cmd = CMD_STOP;
         OP_WRITE: cmd = CMD_WRITE;
         OP_READ:  cmd = CMD_READ;
         OP_NACK:  cmd = CMD_NACK;
         default:  cmd = CMD_TICK;
      endcase
   end

   assign req.ready = !q_status.full;
   assign push = req.valid && !q_status.full;
   assign push_entry = '{cmd: cmd, tx_byte: req.tx_byte, sda_in: req.sda_in};

endmodule

// ===== design/ibm_queue.sv =====
// Two-entry queue of classified transactions between front and back.
// Depends on ibm_pkg.
module ibm_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ibm_pkg::q_entry_type push_entry,
   input  logic                 pop,
   output ibm_pkg::q_entry_type pop_entry,
   output ibm_pkg::q_status_type q_status
);
   import ibm_pkg::*;

   q_entry_type entries_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + (QPTR_W+1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (QPTR_W+1)'(1);
         end
      end
   end

   assign pop_entry = entries_ff[rd_ptr_ff];
   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == (QPTR_W+1)'(QDEPTH));

endmodule

// ===== design/ibm_back.sv =====
// Back end: the pin sequencer, the delay register and the result register.
// Depends on ibm_pkg and ibm_rsp_if.
module ibm_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [ibm_pkg::DELAY_W-1:0] csr_wdata,
   input  ibm_pkg::q_entry_type     pop_entry,
   input  ibm_pkg::q_status_type    q_status,
   output logic                     pop,
   ibm_rsp_if.source                rsp
);
   import ibm_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE, PH_S1, PH_S2, PH_P1, PH_P2, PH_N1, PH_N2, PH_WLO, PH_WHI,
      PH_WACKLO, PH_WACKHI, PH_WTAIL, PH_RPRE, PH_RLO, PH_RHI
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [2:0]            bit_ff, bit_in;
   logic [WAIT_WIDTH-1:0] wait_ff, wait_in;
   logic [7:0]            shift_ff, shift_in;
   logic                  scl_ff, scl_in;
   logic                  sda_ff, sda_in;
   logic                  ack_ff, ack_in;
   logic [7:0]            rx_ff, rx_in;
   logic                  done_ff, done_in;
   logic                  valid_ff, valid_in;
   logic [DELAY_W-1:0]    delay_ff;
   logic [WAIT_WIDTH-1:0] delay_cut, load_val;
   logic [7:0]            shift_rx;

   assign pop = !q_status.empty && (!valid_ff || rsp.ready);
   assign delay_cut = WAIT_WIDTH'(delay_ff);
   assign load_val = (delay_cut == '0) ? WAIT_WIDTH'(1) : delay_cut;

   always_comb begin
      shift_rx = shift_ff;
      shift_rx[bit_ff] = shift_ff[bit_ff] | pop_entry.sda_in;
   end

   always_comb begin
      phase_in = phase_ff;
      bit_in   = bit_ff;
      wait_in  = wait_ff;
      shift_in = shift_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      ack_in   = ack_ff;
      rx_in    = rx_ff;
      done_in  = done_ff;
      valid_in = valid_ff && !rsp.ready;
      if (pop) begin
         valid_in = 1'b1;
         done_in  = 1'b0;
         if (pop_entry.cmd != CMD_TICK) begin
            if (phase_ff == PH_IDLE) begin
               bit_in  = 3'd7;
               wait_in = load_val;
               case (pop_entry.cmd)
                  CMD_START: begin
                     sda_in   = 1'b0;
                     phase_in = PH_S1;
                  end
                  CMD_STOP: begin
                     scl_in   = 1'b1;
                     phase_in = PH_P1;
                  end
                  CMD_WRITE: begin
                     shift_in = pop_entry.tx_byte;
                     sda_in   = pop_entry.tx_byte[7];
                     phase_in = PH_WLO;
                  end
                  CMD_READ: begin
                     shift_in = '0;
                     sda_in   = 1'b1;
                     phase_in = PH_RPRE;
                  end
                  default: begin
                     scl_in   = 1'b0;
                     phase_in = PH_N1;
                  end
               endcase
            end
         end else if (phase_ff != PH_IDLE) begin
            if (wait_ff > WAIT_WIDTH'(1)) begin
               wait_in = wait_ff - WAIT_WIDTH'(1);
            end else begin
               wait_in = '0;
               case (phase_ff)
                  PH_S1: begin
                     scl_in   = 1'b0;
                     wait_in  = load_val;
                     phase_in = PH_S2;
                  end
                  PH_P1: begin
                     sda_in   = 1'b1;
                     wait_in  = load_val;
                     phase_in = PH_P2;
                  end
                  PH_N1: begin
                     scl_in   = 1'b1;
                     wait_in  = load_val;
                     phase_in = PH_N2;
                  end
                  PH_N2: begin
                     scl_in   = 1'b0;
                     phase_in = PH_IDLE;
                     done_in  = 1'b1;
                  end
                  PH_WLO, PH_WACKLO, PH_RLO: begin
                     scl_in  = 1'b1;
                     wait_in = load_val;
                     phase_in = (phase_ff == PH_WLO) ? PH_WHI :
                                (phase_ff == PH_RLO) ? PH_RHI : PH_WACKHI;
                  end
                  PH_WHI: begin
                     scl_in  = 1'b0;
                     wait_in = load_val;
                     if (bit_ff == 3'd0) begin
                        sda_in   = 1'b1;
                        phase_in = PH_WACKLO;
                     end else begin
                        bit_in   = bit_ff - 3'd1;
                        sda_in   = shift_ff[bit_ff - 3'd1];
                        phase_in = PH_WLO;
                     end
                  end
                  PH_WACKHI: begin
                     ack_in   = !pop_entry.sda_in;
                     scl_in   = 1'b0;
                     sda_in   = 1'b0;
                     wait_in  = load_val;
                     phase_in = PH_WTAIL;
                  end
                  PH_RPRE: begin
                     wait_in  = load_val;
                     phase_in = PH_RLO;
                  end
                  PH_RHI: begin
                     shift_in = shift_rx;
                     scl_in   = 1'b0;
                     if (bit_ff == 3'd0) begin
                        rx_in    = shift_rx;
                        phase_in = PH_IDLE;
                        done_in  = 1'b1;
                     end else begin
                        bit_in   = bit_ff - 3'd1;
                        wait_in  = load_val;
                        phase_in = PH_RLO;
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                     done_in  = 1'b1;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         bit_ff   <= 3'd7;
         wait_ff  <= '0;
         shift_ff <= '0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         ack_ff   <= 1'b0;
         rx_ff    <= '0;
         done_ff  <= 1'b0;
         valid_ff <= 1'b0;
         delay_ff <= DELAY_RESET;
      end else begin
         phase_ff <= phase_in;
         bit_ff   <= bit_in;
         wait_ff  <= wait_in;
         shift_ff <= shift_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
         ack_ff   <= ack_in;
         rx_ff    <= rx_in;
         done_ff  <= done_in;
         valid_ff <= valid_in;
         if (csr_we) begin
            delay_ff <= csr_wdata;
         end
      end
   end

   assign rsp.valid    = valid_ff;
   assign rsp.scl_out  = scl_ff;
   assign rsp.sda_out  = sda_ff;
   assign rsp.busy_res = (phase_ff != PH_IDLE);
   assign rsp.done_res = done_ff;
   assign rsp.rx_byte  = rx_ff;
   assign rsp.ack_ok   = ack_ff;

endmodule

// ===== tb/i2c_bit_level_master_checker.sv =====
// Checker for the I2C bit-level master: watches the request, response and delay
// register ports, predicts the pin levels of every response and compares them.
// Depends on ibm_pkg and the channel interfaces in ibm_if.sv.
module i2c_bit_level_master_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [ibm_pkg::DELAY_W-1:0] csr_wdata,
   ibm_req_if                          req,
   ibm_rsp_if                          rsp,
   output int                          fail_count,
   output int                          outstanding,
   output int                          compared,
   output logic                        seq_busy
);
   import ibm_pkg::*;

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_START_HOLD,
      SEQ_START_TAIL,
      SEQ_STOP_HOLD,
      SEQ_STOP_TAIL,
      SEQ_NACK_LOW,
      SEQ_NACK_HIGH,
      SEQ_WR_LOW,
      SEQ_WR_HIGH,
      SEQ_ACK_LOW,
      SEQ_ACK_HIGH,
      SEQ_WR_TAIL,
      SEQ_RD_SETUP,
      SEQ_RD_LOW,
      SEQ_RD_HIGH
   } seq_phase_type;

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       busy;
      logic       done;
      logic [7:0] rx;
      logic       ack;
   } pin_state_type;

   seq_phase_type         phase_q;
   logic [WAIT_WIDTH-1:0] ticks_left;
   logic [2:0]            bit_pos;
   logic [7:0]            shift_q;
   logic                  scl_q;
   logic                  sda_q;
   logic                  ack_q;
   logic [7:0]            rx_q;
   logic [DELAY_W-1:0]    delay_q;
   pin_state_type         pending_pins[$];

   assign seq_busy = (phase_q != SEQ_IDLE);

   function automatic void start_wait(seq_phase_type nxt);
      logic [WAIT_WIDTH-1:0] load;
      load = WAIT_WIDTH'(delay_q);
      ticks_left = (load == '0) ? WAIT_WIDTH'(1) : load;
      phase_q = nxt;
   endfunction

   function automatic void take_command(logic [2:0] op, logic [7:0] data);
      bit_pos = 3'd7;
      case (op)
         OP_START: begin
            sda_q = 1'b0;
            start_wait(SEQ_START_HOLD);
         end
         OP_STOP: begin
            scl_q = 1'b1;
            start_wait(SEQ_STOP_HOLD);
         end
         OP_WRITE: begin
            shift_q = data;
            sda_q = data[7];
            start_wait(SEQ_WR_LOW);
         end
         OP_READ: begin
            shift_q = 8'h00;
            sda_q = 1'b1;
            start_wait(SEQ_RD_SETUP);
         end
         default: begin
            scl_q = 1'b0;
            start_wait(SEQ_NACK_LOW);
         end
      endcase
   endfunction

   // Moves the pins at the end of a wait; returns 1 when the sequence is over.
   function automatic logic finish_wait(logic line);
      logic over;
      over = 1'b0;
      case (phase_q)
         SEQ_START_HOLD: begin
            scl_q = 1'b0;
            start_wait(SEQ_START_TAIL);
         end
         SEQ_STOP_HOLD: begin
            sda_q = 1'b1;
            start_wait(SEQ_STOP_TAIL);
         end
         SEQ_NACK_LOW: begin
            scl_q = 1'b1;
            start_wait(SEQ_NACK_HIGH);
         end
         SEQ_NACK_HIGH: begin
            scl_q = 1'b0;
            over = 1'b1;
         end
         SEQ_WR_LOW: begin
            scl_q = 1'b1;
            start_wait(SEQ_WR_HIGH);
         end
         SEQ_WR_HIGH: begin
            scl_q = 1'b0;
            if (bit_pos == 3'd0) begin
               sda_q = 1'b1;
               start_wait(SEQ_ACK_LOW);
            end else begin
               bit_pos = bit_pos - 3'd1;
               sda_q = shift_q[bit_pos];
               start_wait(SEQ_WR_LOW);
            end
         end
         SEQ_ACK_LOW: begin
            scl_q = 1'b1;
            start_wait(SEQ_ACK_HIGH);
         end
         SEQ_ACK_HIGH: begin
            ack_q = ~line;
            scl_q = 1'b0;
            sda_q = 1'b0;
            start_wait(SEQ_WR_TAIL);
         end
         SEQ_RD_SETUP: begin
            start_wait(SEQ_RD_LOW);
         end
         SEQ_RD_LOW: begin
            scl_q = 1'b1;
            start_wait(SEQ_RD_HIGH);
         end
         SEQ_RD_HIGH: begin
            if (line)
               shift_q[bit_pos] = 1'b1;
            scl_q = 1'b0;
            if (bit_pos == 3'd0) begin
               rx_q = shift_q;
               over = 1'b1;
            end else begin
               bit_pos = bit_pos - 3'd1;
               start_wait(SEQ_RD_LOW);
            end
         end
         default: begin
            over = 1'b1;
         end
      endcase
      return over;
   endfunction

   function automatic pin_state_type advance_sequencer(logic [2:0] op, logic [7:0] data,
                                                       logic line);
      pin_state_type pins;
      logic          over;
      over = 1'b0;
      if (op >= OP_START && op <= OP_NACK) begin
         if (phase_q == SEQ_IDLE)
            take_command(op, data);
      end else if (phase_q != SEQ_IDLE) begin
         if (ticks_left > WAIT_WIDTH'(1)) begin
            ticks_left = ticks_left - WAIT_WIDTH'(1);
         end else begin
            ticks_left = '0;
            over = finish_wait(line);
            if (over)
               phase_q = SEQ_IDLE;
         end
      end
      pins.scl = scl_q;
      pins.sda = sda_q;
      pins.busy = (phase_q != SEQ_IDLE);
      pins.done = over;
      pins.rx = rx_q;
      pins.ack = ack_q;
      return pins;
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      pin_state_type want;
      if (reset) begin
         phase_q = SEQ_IDLE;
         ticks_left = '0;
         bit_pos = 3'd7;
         shift_q = 8'h00;
         scl_q = 1'b1;
         sda_q = 1'b1;
         ack_q = 1'b0;
         rx_q = 8'h00;
         delay_q = DELAY_RESET;
         pending_pins.delete();
         fail_count = 0;
         outstanding = 0;
         compared = 0;
      end else begin
         if (csr_we)
            delay_q = csr_wdata;
         if (req.valid && req.ready)
            pending_pins.push_back(advance_sequencer(req.opcode, req.tx_byte, req.sda_in));
         if (rsp.valid && rsp.ready) begin
            if (pending_pins.size() == 0) begin
               $display("%0t: response transaction with no request outstanding", $time);
               fail_count++;
            end else begin
               want = pending_pins.pop_front();
               check_field("scl_out", 8'(want.scl), 8'(rsp.scl_out));
               check_field("sda_out", 8'(want.sda), 8'(rsp.sda_out));
               check_field("busy_res", 8'(want.busy), 8'(rsp.busy_res));
               check_field("done_res", 8'(want.done), 8'(rsp.done_res));
               check_field("rx_byte", want.rx, rsp.rx_byte);
               check_field("ack_ok", 8'(want.ack), 8'(rsp.ack_ok));
               compared++;
            end
         end
         outstanding = pending_pins.size();
      end
   end

endmodule

// ===== tb/i2c_bit_level_master_top_tb.sv =====
// Testbench top for the I2C bit-level master: drives request transactions, the
// delay register and response back-pressure, and reports the verdict.
// Depends on ibm_pkg, ibm_if.sv, the block and i2c_bit_level_master_checker.
module i2c_bit_level_master_top_tb;
   import ibm_pkg::*;

   localparam logic [2:0] OP_SPARE_SIX = 3'd6;
   localparam logic [2:0] OP_SPARE_SEVEN = 3'd7;
   localparam int STALL_MAX = 16;
   localparam int LONG_HOLD = 48;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int TAIL_CYCLES = 8;
   localparam int LARGE_DELAY_TICKS = 20;

   typedef enum int {
      SDA_LOW,
      SDA_HIGH,
      SDA_RANDOM
   } sda_drive_type;

   logic               clock;
   logic               reset;
   logic               csr_we;
   logic [DELAY_W-1:0] csr_wdata;
   int                 fail_count;
   int                 outstanding;
   int                 compared;
   logic               seq_busy;
   bit                 steady;
   bit                 long_hold_req;
   int                 items_sent;
   int                 sequences_run;
   int                 settings_used;
   int                 idle_cycles;

   ibm_req_if req_ch ();
   ibm_rsp_if rsp_ch ();

   i2c_bit_level_master_top dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req       (req_ch),
      .rsp       (rsp_ch)
   );

   i2c_bit_level_master_checker pin_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .compared    (compared),
      .seq_busy    (seq_busy)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Starts and ends at a falling edge, so valid does not drop between back-to-back items sent without a gap.
   task automatic send_item(input logic [2:0] op, input logic [7:0] data, input logic line);
      int gap;
      gap = steady ? 0 : $urandom_range(0, STALL_MAX);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op;
      req_ch.tx_byte <= data;
      req_ch.sda_in <= line;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic write_delay(input logic [DELAY_W-1:0] value);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic run_sequence(input logic [2:0] cmd, input logic [7:0] data,
                               input sda_drive_type mode, input int noise_pct);
      logic [2:0] op;
      logic       line;
      send_item(cmd, data, 1'($urandom));
      sequences_run++;
      while (seq_busy) begin
         if ($urandom_range(0, 99) < noise_pct)
            op = 3'($urandom_range(OP_START, OP_SPARE_SEVEN));
         else
            op = OP_TICK;
         case (mode)
            SDA_LOW: line = 1'b0;
            SDA_HIGH: line = 1'b1;
            default: line = 1'($urandom);
         endcase
         send_item(op, 8'($urandom), line);
      end
   endtask

   task automatic random_phase(input int budget, input bit with_hold);
      int first;
      first = items_sent;
      if (with_hold) begin
         long_hold_req = 1'b1;
         steady = 1'b1;
         run_sequence(OP_WRITE, 8'($urandom), SDA_RANDOM, 0);
      end
      while (items_sent - first < budget) begin
         case ($urandom_range(0, 19))
            0: begin
               steady = 1'b0;
               send_item(($urandom_range(0, 1) != 0) ? OP_TICK :
                         (($urandom_range(0, 1) != 0) ? OP_SPARE_SIX : OP_SPARE_SEVEN),
                         8'($urandom), 1'($urandom));
            end
            1: wait_drained();
            default: begin
               steady = ($urandom_range(0, 4) == 0);
               run_sequence(3'($urandom_range(OP_START, OP_NACK)), 8'($urandom),
                            sda_drive_type'($urandom_range(0, 2)), 10);
            end
         endcase
      end
      steady = 1'b0;
   endtask

   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold_req) begin
            stall = LONG_HOLD;
            long_hold_req = 1'b0;
         end else if (steady) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, STALL_MAX);
         end
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.opcode = OP_TICK;
      req_ch.tx_byte = 8'h00;
      req_ch.sda_in = 1'b1;
      steady = 1'b0;
      long_hold_req = 1'b0;
      items_sent = 0;
      sequences_run = 0;
      settings_used = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The delay after reset is exercised before the register is ever written.
      run_sequence(OP_NACK, 8'h00, SDA_RANDOM, 0);

      // A delay of zero must behave as a single tick per wait.
      write_delay('0);
      send_item(OP_TICK, 8'hA5, 1'b0);
      send_item(OP_SPARE_SIX, 8'h5A, 1'b1);
      send_item(OP_SPARE_SEVEN, 8'h00, 1'b0);
      run_sequence(OP_START, 8'h00, SDA_HIGH, 0);
      run_sequence(OP_WRITE, 8'hFF, SDA_LOW, 0);
      run_sequence(OP_WRITE, 8'h00, SDA_HIGH, 0);
      run_sequence(OP_READ, 8'h5A, SDA_HIGH, 0);
      run_sequence(OP_READ, 8'hFF, SDA_LOW, 0);
      run_sequence(OP_NACK, 8'hC3, SDA_RANDOM, 0);
      run_sequence(OP_STOP, 8'h3C, SDA_RANDOM, 50);

      write_delay(DELAY_W'(1));
      random_phase(200, 1'b1);
      write_delay(DELAY_W'(3));
      random_phase(120, 1'b0);
      write_delay(DELAY_W'(2));
      random_phase(220, 1'b0);

      // The largest delay is loaded and partly counted down; the sequence is left running.
      write_delay('1);
      steady = 1'b1;
      send_item(OP_START, 8'h00, 1'b1);
      repeat (LARGE_DELAY_TICKS) send_item(OP_TICK, 8'($urandom), 1'($urandom));
      send_item(OP_STOP, 8'h00, 1'b0);
      steady = 1'b0;

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      $display("Sent %0d request transactions in %0d command sequences over %0d delay values,",
               items_sent, sequences_run, settings_used);
      $display("with a long response stall and the largest delay; %0d responses compared.",
               compared);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
